### sv/bta_pkg.sv
// Shared types, constants and helpers for the boundary-tag block allocator.
package bta_pkg;

  localparam int unsigned HEAP_WORDS = 1024;
  localparam int unsigned MEM_DEPTH  = HEAP_WORDS + 3;
  localparam int unsigned IDX_W      = $clog2(MEM_DEPTH);
  localparam int unsigned FIELD_W    = 11;
  localparam int unsigned ADDR_W     = FIELD_W + 1;
  localparam int unsigned SCAN_LIMIT = HEAP_WORDS + 2;
  localparam int unsigned MIN_LEFTOVER_RESET = 10;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RECLAIM = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_ALLOC   = 2'd0,
    STATUS_NOFIT   = 2'd1,
    STATUS_RECLAIM = 2'd2
  } status_e;

  // One heap word: tag (1 = in use), size, left link / foot back-pointer, right link.
  typedef struct packed {
    logic               tag;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] left;
    logic [FIELD_W-1:0] right;
  } word_t;

  localparam int unsigned WORD_W = $bits(word_t);

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_DONE,
    ST_SCAN,
    ST_W_ROVL, ST_W_LR, ST_W_PTAG, ST_W_FTAG,
    ST_S_FTAG, ST_S_PSIZE, ST_S_FOOT, ST_S_Q,
    ST_R_HEAD, ST_R_PREV, ST_R_NEXT,
    ST_E_HEAD, ST_E_FOOT,
    ST_B_PTAG, ST_B_FOOT, ST_B_RL, ST_B_XR, ST_B_RL2, ST_B_PLINK, ST_B_ROVL,
    ST_C_SSIZE, ST_C_FOOT,
    ST_D_TL, ST_D_PL, ST_D_PRD, ST_D_XR, ST_D_TR, ST_D_PR, ST_D_PRD2, ST_D_XL,
    ST_D_TS, ST_D_PS, ST_D_TF, ST_D_FL,
    ST_M_TS, ST_M_SS, ST_M_TLR, ST_M_XR, ST_M_TRL, ST_M_XL, ST_M_TF, ST_M_FL
  } step_e;

  // Map a word address to a memory index; anything past the top sentinel hits scratch.
  function automatic logic [IDX_W-1:0] ix(input logic [ADDR_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a <= ADDR_W'(HEAP_WORDS + 1)) r = IDX_W'(a);
    else r = IDX_W'(HEAP_WORDS + 2);
    return r;
  endfunction

  // Reset image of the heap.
  function automatic word_t init_word(input logic [IDX_W-1:0] i);
    word_t wd;
    wd = '0;
    if (i == IDX_W'(0)) wd.tag = 1'b1;
    if (i == IDX_W'(1)) begin
      wd.size  = FIELD_W'(HEAP_WORDS);
      wd.left  = FIELD_W'(1);
      wd.right = FIELD_W'(1);
    end
    if (i == IDX_W'(HEAP_WORDS)) wd.left = FIELD_W'(1);
    if (i == IDX_W'(HEAP_WORDS + 1)) wd.tag = 1'b1;
    return wd;
  endfunction

endpackage

### sv/bta_if.sv
// Request, response and configuration channel interfaces.
interface bta_req_if import bta_pkg::*; ();
  logic               valid;
  logic               ready;
  cmd_e               command;
  logic [FIELD_W-1:0] request_size;
  logic [FIELD_W-1:0] block_addr;
  modport source (output valid, command, request_size, block_addr, input ready);
  modport sink   (input valid, command, request_size, block_addr, output ready);
endinterface

interface bta_rsp_if import bta_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] granted_addr;
  logic [FIELD_W-1:0] granted_size;
  status_e            status;
  modport source (output valid, granted_addr, granted_size, status, input ready);
  modport sink   (input valid, granted_addr, granted_size, status, output ready);
endinterface

interface bta_cfg_if import bta_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] min_leftover;
  modport source (output valid, min_leftover, input ready);
  modport sink   (input valid, min_leftover, output ready);
endinterface

### sv/boundary_tag_block_allocator.sv
// Top level of the boundary-tag block allocator (next-fit heap manager).
//
// Manages a 1024-word heap held in one 34-bit-wide RAM (words 1..1024 plus a
// sentinel at each end and a scratch word). Each word holds tag, size, left
// link (or foot back-pointer) and right link. After reset a clearing pass
// writes the heap image, one word a cycle; the request channel stays
// not-ready until it ends (config writes are taken throughout).
// A request is handled by a small sequencer around the RAM: every heap access
// is a read whose registered data is then used and optionally written back.
// Allocate reads free blocks in turn from the rover, then takes or splits the
// block that fits; reclaim checks the block and its neighbors, then updates
// links and sizes depending on which neighbors are free. The DONE step moves
// the response into the output register once that register is free or being
// read; the next request is taken while a response still waits there.
// min_leftover may be written at any time the block is idle.
module boundary_tag_block_allocator import bta_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  bta_req_if.sink   req_i,
  bta_rsp_if.source rsp_o,
  bta_cfg_if.sink   cfg_i
);

  step_e              step_q, step_d;
  logic               phase_q, phase_d;
  logic [ADDR_W-1:0]  p_q, p_d, t_q, t_d, f_q, f_d, x_q, x_d;
  logic [FIELD_W-1:0] s_q, s_d, y_q, y_d, sz_q, sz_d, n_q, n_d, rover_q, rover_d;
  logic               l_q, l_d, empty_q, empty_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [FIELD_W-1:0] ml_q, ml_d;
  logic [FIELD_W-1:0] res_addr_q, res_addr_d, res_size_q, res_size_d;
  status_e            res_status_q, res_status_d;
  logic               ovalid_q, ovalid_d;
  logic [FIELD_W-1:0] oaddr_q, oaddr_d, osize_q, osize_d;
  status_e            ostatus_q, ostatus_d;

  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  word_t              wd, rd;
  logic [WORD_W-1:0]  rdata;
  logic [ADDR_W-1:0]  op_addr;

  bta_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(WORD_W'(wd)),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd = word_t'(rdata);

  assign req_i.ready        = (step_q == ST_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign rsp_o.valid        = ovalid_q;
  assign rsp_o.granted_addr = oaddr_q;
  assign rsp_o.granted_size = osize_q;
  assign rsp_o.status       = ostatus_q;

  // Word touched by the current step.
  always_comb begin
    unique case (step_q)
      ST_W_ROVL, ST_B_RL, ST_B_RL2, ST_B_ROVL: op_addr = {1'b0, rover_q};
      ST_W_LR, ST_C_SSIZE, ST_M_SS:            op_addr = {1'b0, s_q};
      ST_W_FTAG, ST_S_FTAG, ST_S_FOOT, ST_E_FOOT, ST_B_FOOT, ST_C_FOOT:
        op_addr = f_q;
      ST_S_Q:    op_addr = f_q + ADDR_W'(1);
      ST_R_PREV: op_addr = p_q - ADDR_W'(1);
      ST_R_NEXT, ST_D_TL, ST_D_TR, ST_D_TS, ST_D_TF, ST_M_TS, ST_M_TLR, ST_M_TRL, ST_M_TF:
        op_addr = t_q;
      ST_B_XR, ST_D_XR, ST_D_XL, ST_D_FL, ST_M_XR, ST_M_XL, ST_M_FL:
        op_addr = x_q;
      default:   op_addr = p_q;
    endcase
  end

  always_comb begin
    step_d = step_q;  phase_d = phase_q;
    p_d = p_q;  t_d = t_q;  f_d = f_q;  x_d = x_q;
    s_d = s_q;  y_d = y_q;  sz_d = sz_q;  n_d = n_q;  rover_d = rover_q;
    l_d = l_q;  empty_d = empty_q;  cnt_d = cnt_q;
    res_addr_d = res_addr_q;  res_size_d = res_size_q;  res_status_d = res_status_q;
    ovalid_d = ovalid_q;  oaddr_d = oaddr_q;  osize_d = osize_q;  ostatus_d = ostatus_q;
    ml_d = ml_q;
    we = 1'b0;
    waddr = ix(op_addr);
    raddr = ix(op_addr);
    wd = rd;

    if (cfg_i.valid) ml_d = cfg_i.min_leftover;
    if (ovalid_q && rsp_o.ready) ovalid_d = 1'b0;

    unique case (step_q)
      ST_CLEAR: begin
        we = 1'b1;
        waddr = cnt_q;
        wd = init_word(cnt_q);
        if (cnt_q == IDX_W'(MEM_DEPTH - 1)) step_d = ST_IDLE;
        else cnt_d = cnt_q + IDX_W'(1);
      end
      ST_IDLE: begin
        phase_d = 1'b0;
        res_addr_d = '0;
        res_size_d = '0;
        if (req_i.valid) begin
          if (req_i.command == CMD_ALLOC) begin
            n_d = req_i.request_size;
            p_d = {1'b0, rover_q};
            cnt_d = '0;
            res_status_d = STATUS_NOFIT;
            if (empty_q || req_i.request_size == '0) step_d = ST_DONE;
            else step_d = ST_SCAN;
          end else begin
            p_d = {1'b0, req_i.block_addr};
            res_status_d = STATUS_RECLAIM;
            if (req_i.block_addr == '0 || req_i.block_addr > FIELD_W'(HEAP_WORDS))
              step_d = ST_DONE;
            else step_d = ST_R_HEAD;
          end
        end
      end
      ST_DONE: begin
        if (!ovalid_q || rsp_o.ready) begin
          ovalid_d = 1'b1;
          oaddr_d = res_addr_q;
          osize_d = res_size_q;
          ostatus_d = res_status_q;
          step_d = ST_IDLE;
        end
      end
      default: begin
        if (!phase_q) begin
          phase_d = 1'b1;      // read issued, data next cycle
        end else begin
          phase_d = 1'b0;
          unique case (step_q)
            ST_SCAN: begin
              if (rd.size < n_q && rd.right != rover_q && cnt_q < IDX_W'(SCAN_LIMIT)) begin
                p_d = {1'b0, rd.right};
                cnt_d = cnt_q + IDX_W'(1);
              end else if (rd.size < n_q) begin
                step_d = ST_DONE;
              end else begin
                f_d = p_q + {1'b0, rd.size} - ADDR_W'(1);
                rover_d = rd.right;
                s_d = rd.left;
                if (rd.size - n_q <= ml_q) begin
                  if ({1'b0, rd.right} == p_q) begin
                    empty_d = 1'b1;
                    rover_d = '0;
                    step_d = ST_W_PTAG;
                  end else step_d = ST_W_ROVL;
                end else step_d = ST_S_FTAG;
              end
            end
            ST_W_ROVL: begin we = 1'b1; wd.left = s_q; step_d = ST_W_LR; end
            ST_W_LR:   begin we = 1'b1; wd.right = rover_q; step_d = ST_W_PTAG; end
            ST_W_PTAG: begin
              we = 1'b1; wd.tag = 1'b1;
              x_d = {1'b0, rd.size};
              step_d = ST_W_FTAG;
            end
            ST_W_FTAG: begin
              we = 1'b1; wd.tag = 1'b1;
              res_addr_d = p_q[FIELD_W-1:0];
              res_size_d = x_q[FIELD_W-1:0];
              res_status_d = STATUS_ALLOC;
              step_d = ST_DONE;
            end
            ST_S_FTAG: begin we = 1'b1; wd.tag = 1'b1; step_d = ST_S_PSIZE; end
            ST_S_PSIZE: begin
              we = 1'b1; wd.size = rd.size - n_q;
              f_d = p_q + {1'b0, rd.size - n_q} - ADDR_W'(1);
              step_d = ST_S_FOOT;
            end
            ST_S_FOOT: begin
              we = 1'b1; wd.tag = 1'b0; wd.left = p_q[FIELD_W-1:0];
              step_d = ST_S_Q;
            end
            ST_S_Q: begin
              we = 1'b1; wd.tag = 1'b1; wd.size = n_q;
              res_addr_d = FIELD_W'(f_q + ADDR_W'(1));
              res_size_d = n_q;
              res_status_d = STATUS_ALLOC;
              step_d = ST_DONE;
            end
            ST_R_HEAD: begin
              if (!rd.tag || rd.size == '0 ||
                  rd.size > FIELD_W'(HEAP_WORDS + 1) - p_q[FIELD_W-1:0]) begin
                step_d = ST_DONE;
              end else begin
                sz_d = rd.size;
                t_d = p_q + {1'b0, rd.size};
                step_d = ST_R_PREV;
              end
            end
            ST_R_PREV: begin s_d = rd.left; l_d = rd.tag; step_d = ST_R_NEXT; end
            ST_R_NEXT: begin
              f_d = p_q + {1'b0, sz_q} - ADDR_W'(1);
              priority if (empty_q)      step_d = ST_E_HEAD;
              else if (l_q && rd.tag)    step_d = ST_B_PTAG;
              else if (rd.tag)           step_d = ST_C_SSIZE;
              else if (l_q)              step_d = ST_D_TL;
              else                       step_d = ST_M_TS;
            end
            // free list was empty: block becomes the whole list
            ST_E_HEAD: begin
              we = 1'b1; wd.tag = 1'b0;
              wd.left = p_q[FIELD_W-1:0]; wd.right = p_q[FIELD_W-1:0];
              rover_d = p_q[FIELD_W-1:0];
              step_d = ST_E_FOOT;
            end
            ST_E_FOOT: begin
              we = 1'b1; wd.tag = 1'b0; wd.left = p_q[FIELD_W-1:0];
              empty_d = 1'b0;
              step_d = ST_DONE;
            end
            // both neighbors in use: insert before rover
            ST_B_PTAG: begin we = 1'b1; wd.tag = 1'b0; step_d = ST_B_FOOT; end
            ST_B_FOOT: begin
              we = 1'b1; wd.tag = 1'b0; wd.left = p_q[FIELD_W-1:0];
              step_d = ST_B_RL;
            end
            ST_B_RL:  begin x_d = {1'b0, rd.left}; step_d = ST_B_XR; end
            ST_B_XR:  begin we = 1'b1; wd.right = p_q[FIELD_W-1:0]; step_d = ST_B_RL2; end
            ST_B_RL2: begin x_d = {1'b0, rd.left}; step_d = ST_B_PLINK; end
            ST_B_PLINK: begin
              we = 1'b1; wd.left = x_q[FIELD_W-1:0]; wd.right = rover_q;
              step_d = ST_B_ROVL;
            end
            ST_B_ROVL: begin
              we = 1'b1; wd.left = p_q[FIELD_W-1:0];
              rover_d = p_q[FIELD_W-1:0];
              step_d = ST_DONE;
            end
            // left free: grow it
            ST_C_SSIZE: begin we = 1'b1; wd.size = rd.size + sz_q; step_d = ST_C_FOOT; end
            ST_C_FOOT: begin
              we = 1'b1; wd.tag = 1'b0; wd.left = s_q;
              step_d = ST_DONE;
            end
            // right free: take over its list place
            ST_D_TL:  begin x_d = {1'b0, rd.left}; step_d = ST_D_PL; end
            ST_D_PL:  begin
              we = 1'b1; wd.tag = 1'b0; wd.left = x_q[FIELD_W-1:0];
              step_d = ST_D_PRD;
            end
            ST_D_PRD: begin x_d = {1'b0, rd.left}; step_d = ST_D_XR; end
            ST_D_XR:  begin we = 1'b1; wd.right = p_q[FIELD_W-1:0]; step_d = ST_D_TR; end
            ST_D_TR:  begin x_d = {1'b0, rd.right}; step_d = ST_D_PR; end
            ST_D_PR:  begin we = 1'b1; wd.right = x_q[FIELD_W-1:0]; step_d = ST_D_PRD2; end
            ST_D_PRD2: begin x_d = {1'b0, rd.right}; step_d = ST_D_XL; end
            ST_D_XL:  begin we = 1'b1; wd.left = p_q[FIELD_W-1:0]; step_d = ST_D_TS; end
            ST_D_TS:  begin x_d = {1'b0, rd.size}; step_d = ST_D_PS; end
            ST_D_PS:  begin
              we = 1'b1; wd.size = rd.size + x_q[FIELD_W-1:0];
              step_d = ST_D_TF;
            end
            ST_D_TF:  begin x_d = t_q + {1'b0, rd.size} - ADDR_W'(1); step_d = ST_D_FL; end
            ST_D_FL:  begin
              we = 1'b1; wd.left = p_q[FIELD_W-1:0];
              if ({1'b0, rover_q} == t_q) rover_d = p_q[FIELD_W-1:0];
              step_d = ST_DONE;
            end
            // both free: fold block and right neighbor into left
            ST_M_TS:  begin x_d = {1'b0, rd.size}; step_d = ST_M_SS; end
            ST_M_SS:  begin
              we = 1'b1; wd.size = rd.size + sz_q + x_q[FIELD_W-1:0];
              step_d = ST_M_TLR;
            end
            ST_M_TLR: begin x_d = {1'b0, rd.left}; y_d = rd.right; step_d = ST_M_XR; end
            ST_M_XR:  begin we = 1'b1; wd.right = y_q; step_d = ST_M_TRL; end
            ST_M_TRL: begin x_d = {1'b0, rd.right}; y_d = rd.left; step_d = ST_M_XL; end
            ST_M_XL:  begin we = 1'b1; wd.left = y_q; step_d = ST_M_TF; end
            ST_M_TF:  begin x_d = t_q + {1'b0, rd.size} - ADDR_W'(1); step_d = ST_M_FL; end
            ST_M_FL:  begin
              we = 1'b1; wd.left = s_q;
              if ({1'b0, rover_q} == t_q) rover_d = s_q;
              step_d = ST_DONE;
            end
            default: step_d = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= ST_CLEAR;
      phase_q  <= 1'b0;
      cnt_q    <= '0;
      rover_q  <= FIELD_W'(1);
      empty_q  <= 1'b0;
      ml_q     <= FIELD_W'(MIN_LEFTOVER_RESET);
      ovalid_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      rover_q  <= rover_d;
      empty_q  <= empty_d;
      ml_q     <= ml_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;  t_q <= t_d;  f_q <= f_d;  x_q <= x_d;
    s_q <= s_d;  y_q <= y_d;  sz_q <= sz_d;  n_q <= n_d;  l_q <= l_d;
    res_addr_q <= res_addr_d;  res_size_q <= res_size_d;  res_status_q <= res_status_d;
    oaddr_q <= oaddr_d;  osize_q <= osize_d;  ostatus_q <= ostatus_d;
  end

endmodule

### sv/bta_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

### sv/bta_checker.sv
// Port-level assertions for the boundary-tag block allocator, bound to the top level.
module bta_checker import bta_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [FIELD_W-1:0] rsp_addr_i,
  input logic [FIELD_W-1:0] rsp_size_i,
  input status_e            rsp_status_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_addr_i)
      && $stable(rsp_size_i) && $stable(rsp_status_i))
    else $error("response changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i == STATUS_ALLOC || rsp_status_i == STATUS_NOFIT
      || rsp_status_i == STATUS_RECLAIM)
    else $error("bad status code");

  a_reclaim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == STATUS_RECLAIM |->
      rsp_addr_i == '0 && rsp_size_i == '0)
    else $error("reclaim response carries a grant");

  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == STATUS_NOFIT |->
      rsp_addr_i == '0 && rsp_size_i == '0)
    else $error("no-fit response carries a grant");

  a_grant_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == STATUS_ALLOC |-> rsp_size_i != '0)
    else $error("grant of zero words");

endmodule

bind boundary_tag_block_allocator bta_checker u_bta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_addr_i  (rsp_o.granted_addr),
  .rsp_size_i  (rsp_o.granted_size),
  .rsp_status_i(rsp_o.status)
);
